// ===== src/window_queue_with_mean_macros.svh =====
// Assertion macros shared by the window queue RTL.
`ifndef WINDOW_QUEUE_WITH_MEAN_MACROS_SVH
`define WINDOW_QUEUE_WITH_MEAN_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define WQM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("window queue check failed");

// Next-cycle implication, disabled while reset is high.
`define WQM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("window queue check failed");

`endif

// ===== src/wqm_pkg.sv =====
// Types and constants shared by the window queue modules.
package wqm_pkg;

   localparam int VALUE_W   = 12;
   localparam int COUNT_W   = 3;
   localparam int DIV_STEPS = VALUE_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_REMOVE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_START,
      ST_DIVIDE
   } state_type;

   typedef struct packed {
      logic accept_en;
      logic rd_en;
      logic update;
      logic div_start;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

// ===== src/wqm_if.sv =====
// Request and response channel interfaces of the window queue.
interface wqm_req_if;
   logic                        valid;
   logic                        ready;
   logic                        action;
   logic [wqm_pkg::VALUE_W-1:0] value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

interface wqm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [wqm_pkg::VALUE_W-1:0] mean;
   logic [wqm_pkg::VALUE_W-1:0] removed_value;
   logic [wqm_pkg::COUNT_W-1:0] count;
   logic                        evicted;
   logic                        empty_error;

   modport source (output valid, output mean, output removed_value, output count,
                   output evicted, output empty_error, input ready);
   modport sink   (input valid, input mean, input removed_value, input count,
                   input evicted, input empty_error, output ready);
endinterface

// ===== src/wqm_ram.sv =====
// Generic single-port-write, registered-read RAM.
module wqm_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 5,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/wqm_div.sv =====
// Restoring divider, one quotient bit per cycle, for the running mean.
module wqm_div #(
   parameter int CNT_W = 3,
   localparam int SUM_W = wqm_pkg::VALUE_W + CNT_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [SUM_W-1:0]            dividend,
   input  logic [CNT_W-1:0]            divisor,
   output logic [wqm_pkg::VALUE_W-1:0] quotient,
   output logic                        done
);

   localparam int VW = wqm_pkg::VALUE_W;

   logic [CNT_W-1:0]           rem_ff, rem_in;
   logic [VW-1:0]              dq_ff, dq_in;
   logic [wqm_pkg::STEP_W-1:0] step_ff, step_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [CNT_W:0]             trial;
   logic                       fits;

   // The quotient is known to stay below 2**VALUE_W, so the upper bits of the
   // dividend are already smaller than the divisor and seed the remainder.
   always_comb begin
      trial   = {rem_ff, dq_ff[VW-1]};
      fits    = trial >= {1'b0, divisor};
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = dividend[SUM_W-1:VW];
         dq_in   = dividend[VW-1:0];
         step_in = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in = fits ? CNT_W'(trial - {1'b0, divisor}) : CNT_W'(trial);
         dq_in  = {dq_ff[VW-2:0], fits};
         if (step_ff == wqm_pkg::STEP_W'(wqm_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
   end

   assign quotient = dq_ff;
   assign done     = done_ff;

endmodule

// ===== src/wqm_ctrl.sv =====
// Sequencing state machine of the window queue.
module wqm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  wqm_pkg::status_type st,
   output wqm_pkg::cmd_type    cmd
);

   wqm_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wqm_pkg::ST_IDLE:   if (st.req_valid) state_in = wqm_pkg::ST_READ;
         wqm_pkg::ST_READ:   state_in = wqm_pkg::ST_UPDATE;
         wqm_pkg::ST_UPDATE: state_in = wqm_pkg::ST_START;
         wqm_pkg::ST_START:  state_in = wqm_pkg::ST_DIVIDE;
         wqm_pkg::ST_DIVIDE: if (st.div_done && st.out_free) state_in = wqm_pkg::ST_IDLE;
         default:            state_in = wqm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         wqm_pkg::ST_IDLE:   cmd.accept_en = 1'b1;
         wqm_pkg::ST_READ:   cmd.rd_en     = 1'b1;
         wqm_pkg::ST_UPDATE: cmd.update    = 1'b1;
         wqm_pkg::ST_START:  cmd.div_start = 1'b1;
         wqm_pkg::ST_DIVIDE: cmd.load_out  = st.div_done && st.out_free;
         default:            cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wqm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/wqm_datapath.sv =====
// Ring storage, running sum, mean divider and response register of the queue.
`include "window_queue_with_mean_macros.svh"

module wqm_datapath #(
   parameter int CAPACITY = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  wqm_pkg::cmd_type     cmd,
   output wqm_pkg::status_type  st,
   wqm_req_if.sink              req_if,
   wqm_rsp_if.source            rsp_if
);

   localparam int VW    = wqm_pkg::VALUE_W;
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SUM_W = VW + CNT_W;
   localparam int TW    = IDX_W + 2;

   logic              act_ff;
   logic [VW-1:0]     val_ff;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [VW-1:0]     pend_removed_ff;
   logic              pend_evicted_ff;
   logic              pend_err_ff;

   logic              out_valid_ff, out_valid_in;
   logic [VW-1:0]     out_mean_ff;
   logic [VW-1:0]     out_removed_ff;
   logic [wqm_pkg::COUNT_W-1:0] out_count_ff;
   logic              out_evicted_ff;
   logic              out_err_ff;

   logic [VW-1:0]     rd_data;
   logic [VW-1:0]     quotient;
   logic              div_done;

   logic              is_insert;
   logic              is_full;
   logic              do_pop;
   logic [IDX_W-1:0]  head_pop;
   logic [CNT_W-1:0]  count_pop;
   logic [TW-1:0]     tail_sum;
   logic [IDX_W-1:0]  tail_idx;
   logic              wr_en;
   logic              capture;

   assign capture   = req_if.valid && cmd.accept_en;
   assign is_insert = (act_ff == wqm_pkg::ACT_INSERT);
   assign is_full   = (count_ff == CNT_W'(CAPACITY));
   assign do_pop    = is_insert ? is_full : (count_ff != '0);

   always_comb begin
      head_pop  = head_ff;
      count_pop = count_ff;
      if (do_pop) begin
         head_pop  = (head_ff == IDX_W'(CAPACITY - 1)) ? '0 : head_ff + 1'b1;
         count_pop = count_ff - 1'b1;
      end
      tail_sum = TW'(head_pop) + TW'(count_pop);
      if (tail_sum >= TW'(CAPACITY)) begin
         tail_sum = tail_sum - TW'(CAPACITY);
      end
      tail_idx = IDX_W'(tail_sum);
   end

   assign wr_en = cmd.update && is_insert;

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      if (cmd.update) begin
         head_in  = head_pop;
         count_in = is_insert ? count_pop + 1'b1 : count_pop;
         sum_in   = sum_ff - (do_pop ? SUM_W'(rd_data) : '0)
                           + (is_insert ? SUM_W'(val_ff) : '0);
      end
   end

   assign out_valid_in = cmd.load_out ? 1'b1 : (rsp_if.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
      if (capture) begin
         act_ff <= req_if.action;
         val_ff <= req_if.value;
      end
      if (cmd.update) begin
         pend_removed_ff <= (!is_insert && do_pop) ? rd_data : '0;
         pend_evicted_ff <= is_insert && is_full;
         pend_err_ff     <= !is_insert && (count_ff == '0);
      end
      if (cmd.load_out) begin
         out_mean_ff    <= (count_ff == '0) ? '0 : quotient;
         out_removed_ff <= pend_removed_ff;
         out_count_ff   <= wqm_pkg::COUNT_W'(count_ff);
         out_evicted_ff <= pend_evicted_ff;
         out_err_ff     <= pend_err_ff;
      end
   end

   wqm_ram #(
      .WIDTH (VW),
      .DEPTH (CAPACITY)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_idx),
      .wr_data (val_ff),
      .rd_en   (cmd.rd_en),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   wqm_div #(
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   assign req_if.ready = cmd.accept_en;

   assign st.req_valid = req_if.valid;
   assign st.div_done  = div_done;
   assign st.out_free  = !out_valid_ff || rsp_if.ready;

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.mean          = out_mean_ff;
   assign rsp_if.removed_value = out_removed_ff;
   assign rsp_if.count         = out_count_ff;
   assign rsp_if.evicted       = out_evicted_ff;
   assign rsp_if.empty_error   = out_err_ff;

   `WQM_ASSERT_NOW(a_empty_sum, clock, reset, count_ff == '0, sum_ff == '0)
   `WQM_ASSERT_NOW(a_err_result, clock, reset, out_valid_ff && out_err_ff,
                   out_count_ff == '0 && out_mean_ff == '0 && out_removed_ff == '0)
   `WQM_ASSERT_NOW(a_evict_full, clock, reset, out_valid_ff && out_evicted_ff,
                   out_count_ff == wqm_pkg::COUNT_W'(CAPACITY))
   `WQM_ASSERT_NEXT(a_div_busy, clock, reset, cmd.div_start, !div_done)

endmodule

// ===== src/window_queue_with_mean.sv =====
// Steps from request transaction to response valid: slot read, queue update, divider load,
// one quotient bit per cycle of the 12-bit mean, and the output load once the response
// register is free. A new request is taken only in the idle state after that; a finished
// response waits in its output register meanwhile.
// Reset is synchronous and active high; it empties the queue and the response register.
// Slot contents are not cleared; only values from slots holding stored entries are ever used.
module window_queue_with_mean #(
   parameter int CAPACITY = 5
) (
   input  logic       clock,
   input  logic       reset,
   wqm_req_if.sink    req_if,
   wqm_rsp_if.source  rsp_if
);

   // The controller only steps through the phases of one transaction; every
   // register that holds queue state or result data lives in the datapath.
   wqm_pkg::cmd_type    cmd;
   wqm_pkg::status_type st;

   wqm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .st    (st),
      .cmd   (cmd)
   );

   // The datapath keeps the ring of slots, the head index, the entry count and
   // the running sum, so the mean never needs a walk over the stored values.
   wqm_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .st     (st),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

endmodule
